>>> rtl/core/time_of_day_alarm_table_defines.svh
// ----------------------------------------------------------------------------
// time_of_day_alarm_table_defines.svh
// Assertion macros for the alarm table checker.
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_ALARM_TABLE_DEFINES_SVH
`define TIME_OF_DAY_ALARM_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TDAT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdat assertion failed");

// next-cycle implication, disabled in reset
`define TDAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdat assertion failed");

`endif

>>> rtl/core/tdat_pkg.sv
// ----------------------------------------------------------------------------
// tdat_pkg
// Types, constants and the power-up schedule for the alarm table.
// ----------------------------------------------------------------------------
package tdat_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int ENTRY_W = HOUR_W + MIN_W;
    localparam int BELL_W  = 8;
    localparam int SCHED_W = 6;
    localparam int CFG_W   = 8;

    localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
    localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
    localparam logic [7:0]        SYNC_MARK = 8'h48;

    // input actions
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_SYNC  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // sync phases
    localparam logic [1:0] PH_WAIT_H = 2'd0;
    localparam logic [1:0] PH_HOUR   = 2'd1;
    localparam logic [1:0] PH_MINUTE = 2'd2;

    // config register indexes
    localparam logic CFG_SCHED_COUNT = 1'b0;
    localparam logic CFG_RING        = 1'b1;

    localparam logic [SCHED_W-1:0] SCHED_RESET = 6'd17;
    localparam logic [BELL_W-1:0]  RING_RESET  = 8'd4;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_step;
        logic finish;
    } tdat_cmd_t;

    typedef struct packed {
        logic rollover;
        logic scan_done;
    } tdat_stat_t;

    // power-up schedule, {hour, minute}
    function automatic logic [ENTRY_W-1:0] default_entry(input logic [IDX_W-1:0] idx);
        logic [ENTRY_W-1:0] e;
        unique case (idx)
            5'd0:    e = {5'd7,  6'd0};
            5'd1:    e = {5'd7,  6'd50};
            5'd2:    e = {5'd8,  6'd40};
            5'd3:    e = {5'd9,  6'd0};
            5'd4:    e = {5'd9,  6'd15};
            5'd5:    e = {5'd9,  6'd30};
            5'd6:    e = {5'd9,  6'd45};
            5'd7:    e = {5'd10, 6'd35};
            5'd8:    e = {5'd11, 6'd25};
            5'd9:    e = {5'd12, 6'd15};
            5'd10:   e = {5'd13, 6'd0};
            5'd11:   e = {5'd15, 6'd0};
            5'd12:   e = {5'd15, 6'd15};
            5'd13:   e = {5'd15, 6'd30};
            5'd14:   e = {5'd15, 6'd45};
            5'd15:   e = {5'd17, 6'd25};
            5'd16:   e = {5'd18, 6'd20};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

>>> rtl/core/time_of_day_alarm_table.sv
// ----------------------------------------------------------------------------
// time_of_day_alarm_table
// Time-of-day clock with a 32-entry alarm schedule and a bell countdown.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------------
//   item in  | start high, busy low    | action, rx_byte, entry_index,
//            |                         | entry_hour, entry_minute
//   result   | done, one-cycle strobe  | bell_on, bell_started, clock_hour,
//            |                         | clock_minute, clock_second
//   config   | cfg_we, no wait         | cfg_index, cfg_wdata
//
// Any item but a tick that rolls the minute over passes through the execute and
// finish states, and done is registered from the finish state. A tick that rolls
// the minute over also walks the first N = min(schedule_count, 32) schedule
// entries one entry a cycle through the single read port between those states.
// busy stays high until the cycle done strobes; a new item may transfer in that
// cycle. rst_n is asynchronous; after reset the schedule reads as its power-up
// times. The result receiver cannot stall.
// ----------------------------------------------------------------------------
module time_of_day_alarm_table (
    input  logic                          clk,
    input  logic                          rst_n,
    // item in
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic [7:0]                    rx_byte,
    input  logic [tdat_pkg::IDX_W-1:0]    entry_index,
    input  logic [tdat_pkg::HOUR_W-1:0]   entry_hour,
    input  logic [tdat_pkg::MIN_W-1:0]    entry_minute,
    // config
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [tdat_pkg::CFG_W-1:0]    cfg_wdata,
    // result
    output logic                          done,
    output logic                          bell_on,
    output logic                          bell_started,
    output logic [tdat_pkg::HOUR_W-1:0]   clock_hour,
    output logic [tdat_pkg::MIN_W-1:0]    clock_minute,
    output logic [tdat_pkg::SEC_W-1:0]    clock_second
);
    import tdat_pkg::*;

    tdat_cmd_t  cmd;
    tdat_stat_t stat;

    // sequencer: idle -> execute -> (scan) -> finish
    tdat_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    // datapath state, the schedule memory and the result registers
    tdat_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .rx_byte      (rx_byte),
        .entry_index  (entry_index),
        .entry_hour   (entry_hour),
        .entry_minute (entry_minute),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .bell_on      (bell_on),
        .bell_started (bell_started),
        .clock_hour   (clock_hour),
        .clock_minute (clock_minute),
        .clock_second (clock_second)
    );

endmodule

>>> rtl/core/tdat_ctrl.sv
// ----------------------------------------------------------------------------
// tdat_ctrl
// Sequencer: execute, optional table scan, finish.
// ----------------------------------------------------------------------------
module tdat_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  tdat_pkg::tdat_stat_t  stat,
    output logic                  busy,
    output tdat_pkg::tdat_cmd_t   cmd
);
    import tdat_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.rollover ? S_SCAN : S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> rtl/core/tdat_dp.sv
// ----------------------------------------------------------------------------
// tdat_dp
// Clock counters, sync parser, bell countdown, schedule memory and scan.
// ----------------------------------------------------------------------------
module tdat_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tdat_pkg::tdat_cmd_t           cmd,
    output tdat_pkg::tdat_stat_t          stat,
    input  logic [1:0]                    action,
    input  logic [7:0]                    rx_byte,
    input  logic [tdat_pkg::IDX_W-1:0]    entry_index,
    input  logic [tdat_pkg::HOUR_W-1:0]   entry_hour,
    input  logic [tdat_pkg::MIN_W-1:0]    entry_minute,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [tdat_pkg::CFG_W-1:0]    cfg_wdata,
    output logic                          done,
    output logic                          bell_on,
    output logic                          bell_started,
    output logic [tdat_pkg::HOUR_W-1:0]   clock_hour,
    output logic [tdat_pkg::MIN_W-1:0]    clock_minute,
    output logic [tdat_pkg::SEC_W-1:0]    clock_second
);
    import tdat_pkg::*;

    // latched item
    logic [1:0]         act_reg;
    logic [7:0]         rx_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [HOUR_W-1:0]  eh_reg;
    logic [MIN_W-1:0]   em_reg;

    // config
    logic [SCHED_W-1:0] sched_reg;
    logic [BELL_W-1:0]  ring_reg;

    // clock state
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [1:0]         phase_reg, phase_next;
    logic [BELL_W-1:0]  bell_reg, bell_next;

    // schedule memory and scan
    logic [ENTRY_W-1:0]     mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   rd_valid_reg;
    logic [IDX_W-1:0]       rd_addr_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       scan_lim;
    logic                   pend_reg;
    logic                   hit_reg;
    logic                   scan_issue;
    logic                   wr_en;
    logic [ENTRY_W-1:0]     entry;
    logic                   match;

    logic                   done_reg;
    logic                   bell_on_reg;
    logic                   started_reg;
    logic [HOUR_W-1:0]      out_hour_reg;
    logic [MIN_W-1:0]       out_min_reg;
    logic [SEC_W-1:0]       out_sec_reg;

    assign scan_lim   = (sched_reg > SCHED_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                            : CNT_W'(sched_reg);
    assign scan_issue = cmd.scan_step && (cnt_reg != scan_lim);
    assign wr_en      = cmd.exec && (act_reg == ACT_WRITE);
    assign entry      = rd_valid_reg ? rd_data_reg : default_entry(rd_addr_reg);
    assign match      = (entry[ENTRY_W-1:MIN_W] == hour_reg) && (entry[MIN_W-1:0] == min_reg);

    assign stat.rollover  = (act_reg == ACT_TICK) && (sec_reg >= SEC_LAST);
    assign stat.scan_done = (cnt_reg == scan_lim) && !pend_reg;

    always_comb
    begin
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        phase_next = phase_reg;
        bell_next  = bell_reg;
        if (cmd.exec)
        begin
            unique case (act_reg)
                ACT_TICK:
                begin
                    if (bell_reg != '0)
                        bell_next = bell_reg - BELL_W'(1);
                    if (sec_reg >= SEC_LAST)
                    begin
                        sec_next = '0;
                        if (min_reg >= MIN_LAST)
                        begin
                            min_next  = '0;
                            hour_next = (hour_reg >= HOUR_LAST) ? '0
                                                                : hour_reg + HOUR_W'(1);
                        end
                        else
                        begin
                            min_next = min_reg + MIN_W'(1);
                        end
                    end
                    else
                    begin
                        sec_next = sec_reg + SEC_W'(1);
                    end
                end
                ACT_SYNC:
                begin
                    if (phase_reg == PH_HOUR)
                    begin
                        hour_next  = (rx_reg > 8'(HOUR_LAST)) ? HOUR_LAST : rx_reg[HOUR_W-1:0];
                        phase_next = PH_MINUTE;
                    end
                    else if (phase_reg == PH_MINUTE)
                    begin
                        min_next   = (rx_reg > 8'(MIN_LAST)) ? MIN_LAST : rx_reg[MIN_W-1:0];
                        sec_next   = '0;
                        phase_next = PH_WAIT_H;
                    end
                    else
                    begin
                        phase_next = (rx_reg == SYNC_MARK) ? PH_HOUR : PH_WAIT_H;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.finish && hit_reg)
        begin
            bell_next = ring_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_reg <= SCHED_RESET;
            ring_reg  <= RING_RESET;
            hour_reg  <= '0;
            min_reg   <= '0;
            sec_reg   <= '0;
            phase_reg <= PH_WAIT_H;
            bell_reg  <= '0;
            valid_reg <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SCHED_COUNT: sched_reg <= cfg_wdata[SCHED_W-1:0];
                    CFG_RING:        ring_reg  <= cfg_wdata[BELL_W-1:0];
                    default:         ;
                endcase
            end
            hour_reg  <= hour_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            phase_reg <= phase_next;
            bell_reg  <= bell_next;
            if (wr_en)
                valid_reg[idx_reg] <= 1'b1;
            if (cmd.exec)
                cnt_reg <= '0;
            else if (scan_issue)
                cnt_reg <= cnt_reg + CNT_W'(1);
            pend_reg <= scan_issue;
            if (cmd.exec)
                hit_reg <= 1'b0;
            else if (pend_reg && match)
                hit_reg <= 1'b1;
            done_reg <= cmd.finish;
        end
    end

    // schedule memory: one write or one read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[idx_reg] <= {eh_reg, em_reg};
        if (scan_issue)
            rd_data_reg <= mem[cnt_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            rx_reg  <= rx_byte;
            idx_reg <= entry_index;
            eh_reg  <= entry_hour;
            em_reg  <= entry_minute;
        end
        if (scan_issue)
        begin
            rd_valid_reg <= valid_reg[cnt_reg[IDX_W-1:0]];
            rd_addr_reg  <= cnt_reg[IDX_W-1:0];
        end
        if (cmd.finish)
        begin
            bell_on_reg  <= (bell_next != '0);
            started_reg  <= hit_reg;
            out_hour_reg <= hour_reg;
            out_min_reg  <= min_reg;
            out_sec_reg  <= sec_reg;
        end
    end

    assign done         = done_reg;
    assign bell_on      = bell_on_reg;
    assign bell_started = started_reg;
    assign clock_hour   = out_hour_reg;
    assign clock_minute = out_min_reg;
    assign clock_second = out_sec_reg;

endmodule

>>> rtl/core/tdat_checker.sv
// ----------------------------------------------------------------------------
// tdat_checker
// Port-level checks on the alarm table, bound to the top level.
// ----------------------------------------------------------------------------
`include "time_of_day_alarm_table_defines.svh"

module tdat_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          done,
    input  logic                          bell_started,
    input  logic [tdat_pkg::SEC_W-1:0]    clock_second
);
    import tdat_pkg::*;

    // a transfer makes the block busy
    `TDAT_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)

    // every busy period ends with a result
    `TDAT_ASSERT_IMPLY(a_fall_done, clk, rst_n, $fell(busy), done)

    // results never come back to back
    `TDAT_ASSERT_NEXT(a_done_gap, clk, rst_n, done, !done)

    // a bell start only happens on a minute rollover
    `TDAT_ASSERT_IMPLY(a_start_sec0, clk, rst_n, done && bell_started, clock_second == '0)

endmodule

bind time_of_day_alarm_table tdat_checker u_tdat_checker (.*);

>>> verif/tb_time_of_day_alarm_table.sv
// ----------------------------------------------------------------------------
// tb_time_of_day_alarm_table
// Self-checking bench for the alarm-table clock. A queue-fed driver offers
// ticks, sync bytes and table writes. An in-bench clock model predicts every
// status result, and a monitor compares each done strobe against that model.
// Phases move through several schedule-count and ring-time settings, and
// several sender idle rates.
// ----------------------------------------------------------------------------
module tb_time_of_day_alarm_table;

    import tdat_pkg::*;

    // action code with no function; the block just reports its state
    localparam logic [1:0] ACT_NONE = 2'd3;

    // per-phase random item budget and the settle window at the end
    localparam int PHASE_ITEMS  = 277;
    localparam int DRAIN_CYCLES = 40;

    // power-up alarm times, {hour, minute}; slot 0 sits in the low bits
    localparam int BOOT_ALARMS = 17;
    localparam logic [BOOT_ALARMS*ENTRY_W-1:0] BOOT_TABLE = {
        {5'd18, 6'd20}, {5'd17, 6'd25}, {5'd15, 6'd45}, {5'd15, 6'd30},
        {5'd15, 6'd15}, {5'd15, 6'd0},  {5'd13, 6'd0},  {5'd12, 6'd15},
        {5'd11, 6'd25}, {5'd10, 6'd35}, {5'd9,  6'd45}, {5'd9,  6'd30},
        {5'd9,  6'd15}, {5'd9,  6'd0},  {5'd8,  6'd40}, {5'd7,  6'd50},
        {5'd7,  6'd0}
    };

    typedef struct packed {
        logic [1:0]        action;
        logic [7:0]        rx_byte;
        logic [IDX_W-1:0]  entry_index;
        logic [HOUR_W-1:0] entry_hour;
        logic [MIN_W-1:0]  entry_minute;
    } clock_item_t;

    typedef struct packed {
        logic              bell_on;
        logic              bell_started;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } clock_status_t;

    // ------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               start     = 1'b0;
    clock_item_t        offer     = '0;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;

    logic               busy;
    logic               done;
    logic               bell_on;
    logic               bell_started;
    logic [HOUR_W-1:0]  clock_hour;
    logic [MIN_W-1:0]   clock_minute;
    logic [SEC_W-1:0]   clock_second;

    initial forever #4 clk = ~clk;

    // single reset pulse, released on a clock edge
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    time_of_day_alarm_table u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (offer.action),
        .rx_byte      (offer.rx_byte),
        .entry_index  (offer.entry_index),
        .entry_hour   (offer.entry_hour),
        .entry_minute (offer.entry_minute),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .bell_on      (bell_on),
        .bell_started (bell_started),
        .clock_hour   (clock_hour),
        .clock_minute (clock_minute),
        .clock_second (clock_second)
    );

    // ------------------------------------------------------------------
    // clock model: time of day, sync parser, bell countdown, alarm table
    // ------------------------------------------------------------------
    logic [HOUR_W-1:0]  hour_now;
    logic [MIN_W-1:0]   min_now;
    logic [SEC_W-1:0]   sec_now;
    logic [1:0]         sync_state;
    logic [BELL_W-1:0]  bell_left;
    logic [HOUR_W-1:0]  alarm_hour [MAX_ENTRIES];
    logic [MIN_W-1:0]   alarm_min  [MAX_ENTRIES];
    logic [SCHED_W-1:0] sched_cfg;
    logic [BELL_W-1:0]  ring_cfg;

    clock_item_t   pending_items [$];   // stimulus not yet offered
    clock_status_t status_due [$];      // predicted results, oldest first
    int            items_in_flight = 0; // offered or transferred, no result yet
    int            mismatch_count  = 0;
    int            sender_idle_pct = 0;

    // stimulus-side view: sync phase of the queued stream, active slots
    logic [1:0]    gen_phase = PH_WAIT_H;
    int            gen_sched = 17;
    int            queued_count = 0;

    task automatic load_boot_schedule();
        int i;
        hour_now   = '0;
        min_now    = '0;
        sec_now    = '0;
        sync_state = PH_WAIT_H;
        bell_left  = '0;
        sched_cfg  = SCHED_RESET;
        ring_cfg   = RING_RESET;
        for (i = 0; i < MAX_ENTRIES; i++)
        begin
            if (i < BOOT_ALARMS)
                {alarm_hour[i], alarm_min[i]} = BOOT_TABLE[i*ENTRY_W +: ENTRY_W];
            else
                {alarm_hour[i], alarm_min[i]} = '0;
        end
    endtask

    // Apply one transferred item to the model, return the status it leaves.
    function automatic clock_status_t advance_clock(input clock_item_t it);
        clock_status_t r;
        logic          hit;
        int            scan_n;
        hit = 1'b0;
        case (it.action)
            ACT_TICK:
            begin
                // countdown runs first; a match on this tick reloads it
                if (bell_left != '0)
                    bell_left = bell_left - BELL_W'(1);
                if (sec_now == SEC_LAST)
                begin
                    sec_now = '0;
                    if (min_now == MIN_LAST)
                    begin
                        min_now  = '0;
                        hour_now = (hour_now == HOUR_LAST) ? '0 : hour_now + HOUR_W'(1);
                    end
                    else
                        min_now = min_now + MIN_W'(1);
                    // count above the table size scans the whole table
                    scan_n = (int'(sched_cfg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(sched_cfg);
                    for (int i = 0; i < scan_n; i++)
                        if (alarm_hour[i] == hour_now && alarm_min[i] == min_now)
                            hit = 1'b1;
                    if (hit)
                        bell_left = ring_cfg;
                end
                else
                    sec_now = sec_now + SEC_W'(1);
            end
            ACT_SYNC:
            begin
                case (sync_state)
                    PH_HOUR:
                    begin
                        hour_now   = (it.rx_byte > 8'(HOUR_LAST)) ? HOUR_LAST
                                                                  : it.rx_byte[HOUR_W-1:0];
                        sync_state = PH_MINUTE;
                    end
                    PH_MINUTE:
                    begin
                        min_now    = (it.rx_byte > 8'(MIN_LAST)) ? MIN_LAST
                                                                 : it.rx_byte[MIN_W-1:0];
                        sec_now    = '0;
                        sync_state = PH_WAIT_H;
                    end
                    // waiting, and the unused phase: only 'H' moves on
                    default:
                        sync_state = (it.rx_byte == SYNC_MARK) ? PH_HOUR : PH_WAIT_H;
                endcase
            end
            ACT_WRITE:
            begin
                // values are stored raw; out-of-range times just never match
                alarm_hour[it.entry_index] = it.entry_hour;
                alarm_min[it.entry_index]  = it.entry_minute;
            end
            default: ;
        endcase
        r.bell_on      = (bell_left != '0);
        r.bell_started = hit;
        r.hour         = hour_now;
        r.minute       = min_now;
        r.second       = sec_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver: offers the next pending item, holds it until transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            // transfer on this edge: predict now, config cannot change under it
            if (start && !busy)
                status_due.push_back(advance_clock(offer));
            // free to move on once nothing is held against busy
            if (!start || !busy)
            begin
                if (pending_items.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    offer <= pending_items.pop_front();
                    items_in_flight++;
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every done strobe is checked against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        clock_status_t want;
        clock_status_t got;
        if (rst_n && done)
        begin
            got = {bell_on, bell_started, clock_hour, clock_minute, clock_second};
            if (status_due.size() == 0)
            begin
                $error("done strobe with no result expected");
                mismatch_count++;
            end
            else
            begin
                want = status_due.pop_front();
                items_in_flight--;
                if (got.bell_on !== want.bell_on)
                begin
                    $error("bell_on: expected %0d, actual %0d", want.bell_on, got.bell_on);
                    mismatch_count++;
                end
                if (got.bell_started !== want.bell_started)
                begin
                    $error("bell_started: expected %0d, actual %0d",
                           want.bell_started, got.bell_started);
                    mismatch_count++;
                end
                if (got.hour !== want.hour)
                begin
                    $error("clock_hour: expected %0d, actual %0d", want.hour, got.hour);
                    mismatch_count++;
                end
                if (got.minute !== want.minute)
                begin
                    $error("clock_minute: expected %0d, actual %0d", want.minute, got.minute);
                    mismatch_count++;
                end
                if (got.second !== want.second)
                begin
                    $error("clock_second: expected %0d, actual %0d", want.second, got.second);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // all fields random; callers override what the item is meant to carry
    function automatic clock_item_t random_item();
        logic [31:0] raw;
        raw = $urandom;
        return raw[$bits(clock_item_t)-1:0];
    endfunction

    task automatic queue_item(input clock_item_t it);
        // track the sync parser so runs can start from the waiting phase
        if (it.action == ACT_SYNC)
        begin
            case (gen_phase)
                PH_HOUR:   gen_phase = PH_MINUTE;
                PH_MINUTE: gen_phase = PH_WAIT_H;
                default:   gen_phase = (it.rx_byte == SYNC_MARK) ? PH_HOUR : PH_WAIT_H;
            endcase
        end
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic queue_tick();
        clock_item_t it;
        it        = random_item();
        it.action = ACT_TICK;
        queue_item(it);
    endtask

    task automatic queue_sync_byte(input int b);
        clock_item_t it;
        it         = random_item();
        it.action  = ACT_SYNC;
        it.rx_byte = b[7:0];
        queue_item(it);
    endtask

    task automatic queue_entry(input int slot, input int hr, input int mn);
        clock_item_t it;
        it              = random_item();
        it.action       = ACT_WRITE;
        it.entry_index  = slot[IDX_W-1:0];
        it.entry_hour   = hr[HOUR_W-1:0];
        it.entry_minute = mn[MIN_W-1:0];
        queue_item(it);
    endtask

    // Alarm run: sync to one minute before a target, program a slot with the
    // target, tick across the rollover. Sometimes a second slot one minute
    // later, so a match can land while the bell is still counting down.
    // Random noise items follow, which may leave the parser mid-sequence.
    task automatic queue_alarm_run();
        int th;
        int tm;
        int ph;
        int pm;
        int slot;
        int links;
        int k;
        int noise;
        clock_item_t it;
        // get the parser back to waiting for 'H'
        while (gen_phase != PH_WAIT_H)
            queue_sync_byte($urandom_range(0, SYNC_MARK - 1));
        links = ($urandom_range(0, 2) == 0) ? 2 : 1;
        if ($urandom_range(0, 7) == 0)
        begin
            th = 0;     // midnight: forces the day wrap
            tm = 0;
        end
        else
        begin
            th = $urandom_range(0, 23);
            tm = $urandom_range(0, 59);
        end
        if (tm != 0)
        begin
            ph = th;
            pm = tm - 1;
        end
        else
        begin
            pm = 59;
            ph = (th == 0) ? 23 : th - 1;
        end
        queue_sync_byte(SYNC_MARK);
        // at the top values, oversize bytes clamp to the same time
        queue_sync_byte((ph == 23 && $urandom_range(0, 1)) ? $urandom_range(24, 255) : ph);
        queue_sync_byte((pm == 59 && $urandom_range(0, 1)) ? $urandom_range(60, 255) : pm);
        for (k = 0; k < links; k++)
        begin
            if (gen_sched != 0 && $urandom_range(0, 3) != 0)
                slot = $urandom_range(0, gen_sched - 1);
            else
                slot = $urandom_range(0, MAX_ENTRIES - 1);
            case ($urandom_range(0, 9))
                0:       queue_entry(slot, $urandom_range(24, 31), tm);
                1:       queue_entry(slot, th, $urandom_range(60, 63));
                default: queue_entry(slot, th, tm);
            endcase
            repeat (60) queue_tick();
            if (tm == 59)
            begin
                tm = 0;
                th = (th == 23) ? 0 : th + 1;
            end
            else
                tm = tm + 1;
        end
        repeat ($urandom_range(0, 4)) queue_tick();
        noise = $urandom_range(0, 6);
        repeat (noise)
        begin
            it = random_item();
            if (it.action == ACT_SYNC && $urandom_range(0, 3) == 0)
                it.rx_byte = SYNC_MARK;
            queue_item(it);
        end
    endtask

    // quiet: nothing pending, nothing offered, every result back
    task automatic wait_quiet();
        while (pending_items.size() != 0 || items_in_flight != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_SCHED_COUNT)
            sched_cfg = value[SCHED_W-1:0];
        else
            ring_cfg = value[BELL_W-1:0];
    endtask

    task automatic run_phase(input int sc, input int ring, input int idle_pct,
                             input bit reprogram);
        int mark;
        wait_quiet();
        if (reprogram)
        begin
            write_reg(CFG_SCHED_COUNT, sc);
            write_reg(CFG_RING, ring);
        end
        sender_idle_pct = idle_pct;
        gen_sched = (sc > MAX_ENTRIES) ? MAX_ENTRIES : sc;
        mark = queued_count;
        while (queued_count - mark < PHASE_ITEMS)
            queue_alarm_run();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        load_boot_schedule();
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // directed items on the power-up settings
        sender_idle_pct = 33;
        queue_item('1);                 // unused action, every field bit set
        queue_item('0);                 // plain tick, every field bit clear
        queue_sync_byte(8'h00);         // not 'H' while waiting: ignored
        queue_sync_byte(SYNC_MARK);     // fully oversize hour and minute
        queue_sync_byte(8'hFF);
        queue_sync_byte(8'hFF);
        queue_sync_byte(SYNC_MARK);     // first values past the limits
        queue_sync_byte(24);
        queue_sync_byte(60);
        queue_sync_byte(SYNC_MARK);     // 'H' in the hour slot is an hour
        queue_sync_byte(SYNC_MARK);
        queue_sync_byte(0);
        queue_sync_byte(SYNC_MARK);     // back to midnight
        queue_sync_byte(0);
        queue_sync_byte(0);
        queue_entry(31, 31, 63);        // out-of-range time, never matches
        queue_entry(0, 0, 0);
        queue_entry(16, 0, 1);          // last active slot, one past midnight
        queue_entry(17, 23, 59);        // first inactive slot
        repeat (3) queue_tick();

        // settings include an empty scan, oversize counts and a zero ring
        run_phase(17,  4,   33, 1'b0);
        run_phase(32,  255, 33, 1'b1);
        run_phase(0,   1,   77, 1'b1);
        run_phase(63,  0,   77, 1'b1);
        run_phase(40,  128, 0,  1'b1);
        run_phase(1,   60,  0,  1'b1);

        wait_quiet();
        // catch any stray strobe after the last result
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && status_due.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial
    begin
        #4_800_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/tdat_pkg.sv
rtl/core/tdat_ctrl.sv
rtl/core/tdat_dp.sv
rtl/core/time_of_day_alarm_table.sv
rtl/core/tdat_checker.sv
verif/tb_time_of_day_alarm_table.sv
